[rtl/tsac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_pkg
// Shared types and constants of the turn-signal auto-cancel block.
// ----------------------------------------------------------------------------
package tsac_pkg;

   localparam int SESSION_ID_BITS_DEF = 32;
   localparam int SESSION_ID_PORT_BITS = 32;
   localparam int REQ_DATA_BITS = 152;
   localparam int RSP_DATA_BITS = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [15:0] HEADING_FULL_CDEG = 16'd36000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TURN_STEER   = 3'd0,
      REG_CENTRE_STEER = 3'd1,
      REG_MIN_TURN     = 3'd2,
      REG_MIN_SPEED    = 3'd3,
      REG_MAX_GAP      = 3'd4,
      REG_MAX_JUMP     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_OFF   = 2'd0,
      DIR_LEFT  = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_OTHER = 2'd3
   } dir_type;

   typedef struct packed {
      logic [10:0] turn_steer_mrad;
      logic [10:0] centre_steer_mrad;
      logic [15:0] min_turn_cdeg;
      logic [16:0] min_speed_mm_s;
      logic [31:0] max_gap_ns;
      logic [14:0] max_jump_cdeg;
   } cfg_type;

   // classified sample handed from the front to the back
   typedef struct packed {
      logic        clear;
      logic [1:0]  direction;
      logic        left;
      logic [62:0] sim_time_ns;
      logic [15:0] heading_cdeg;
      logic        speed_ok;
      logic        opposite_steer;
      logic        turning_steer;
      logic        centred_steer;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[rtl/tsac_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_csr
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
module tsac_csr
   import tsac_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_TURN_STEER:   cfg_in.turn_steer_mrad   = csr_wdata[10:0];
            REG_CENTRE_STEER: cfg_in.centre_steer_mrad = csr_wdata[10:0];
            REG_MIN_TURN:     cfg_in.min_turn_cdeg     = csr_wdata[15:0];
            REG_MIN_SPEED:    cfg_in.min_speed_mm_s    = csr_wdata[16:0];
            REG_MAX_GAP:      cfg_in.max_gap_ns        = csr_wdata[31:0];
            REG_MAX_JUMP:     cfg_in.max_jump_cdeg     = csr_wdata[14:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.turn_steer_mrad   <= 11'd120;
         cfg_ff.centre_steer_mrad <= 11'd35;
         cfg_ff.min_turn_cdeg     <= 16'd800;
         cfg_ff.min_speed_mm_s    <= 17'd500;
         cfg_ff.max_gap_ns        <= 32'd250000000;
         cfg_ff.max_jump_cdeg     <= 15'd4500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/tsac_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_front
// Sample classifier: validity, heading reduction and steering/speed tests.
// ----------------------------------------------------------------------------
module tsac_front
   import tsac_pkg::*;
#(
   parameter int SID_BITS = SESSION_ID_PORT_BITS
)
(
   input  cfg_type                         cfg,
   input  logic [1:0]                      direction,
   input  logic                            hazard,
   input  logic                            fresh,
   input  logic                            sample_valid,
   input  logic                            session_valid,
   input  logic [SESSION_ID_PORT_BITS-1:0] session_id,
   input  logic [62:0]                     sim_time_ns,
   input  logic [15:0]                     heading_cdeg,
   input  logic signed [11:0]              steering_mrad,
   input  logic signed [17:0]              speed_mm_s,
   output item_type                        item,
   output logic [SID_BITS-1:0]             sid
);

   logic               dir_active;
   logic               left;
   logic signed [12:0] side_steer;
   logic signed [12:0] centre_s;
   logic signed [12:0] turn_s;

   always_comb begin
      left       = (dir_type'(direction) == DIR_LEFT);
      dir_active = left || (dir_type'(direction) == DIR_RIGHT);
      side_steer = left ? 13'(steering_mrad) : -13'(steering_mrad);
      centre_s   = $signed({2'b00, cfg.centre_steer_mrad});
      turn_s     = $signed({2'b00, cfg.turn_steer_mrad});

      item.clear          = hazard || !dir_active || !fresh || !session_valid
                            || !sample_valid;
      item.direction      = direction;
      item.left           = left;
      item.sim_time_ns    = sim_time_ns;
      // heading below twice the full circle: one subtract reduces it
      item.heading_cdeg   = (heading_cdeg >= HEADING_FULL_CDEG)
                            ? heading_cdeg - HEADING_FULL_CDEG : heading_cdeg;
      item.speed_ok       = $signed({speed_mm_s[17], speed_mm_s})
                            >= $signed({2'b00, cfg.min_speed_mm_s});
      item.opposite_steer = side_steer < -centre_s;
      item.turning_steer  = side_steer >= turn_s;
      item.centred_steer  = (side_steer <= centre_s) && (side_steer >= -centre_s);
      sid                 = session_id[SID_BITS-1:0];
   end

endmodule

[rtl/tsac_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_queue
// Two-entry show-ahead queue between the classifier and the tracker.
// ----------------------------------------------------------------------------
module tsac_queue
   import tsac_pkg::*;
#(
   parameter int DATA_BITS = 8
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output queue_status_type     status
);

   logic [DATA_BITS-1:0] entry_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      status.empty = (count_ff == 2'd0);
      status.full  = (count_ff == 2'd2);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = wr_ptr_ff ^ do_push;
      rd_ptr_in    = rd_ptr_ff ^ do_pop;
      count_in     = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      pop_data     = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/tsac_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsac_back
// Turn tracker: keeps the tracking state and registers one decision per sample.
// ----------------------------------------------------------------------------
module tsac_back
   import tsac_pkg::*;
#(
   parameter int SID_BITS = SESSION_ID_PORT_BITS
)
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   input  item_type            q_item,
   input  logic [SID_BITS-1:0] q_sid,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_cancel,
   output logic                rsp_armed
);

   logic [1:0]          dir_ff, dir_in;
   logic [SID_BITS-1:0] sess_ff, sess_in;
   logic                have_ff, have_in;
   logic [62:0]         last_t_ff, last_t_in;
   logic [15:0]         last_h_ff, last_h_in;
   logic                wait_ff, wait_in;
   logic                seen_ff, seen_in;
   logic [15:0]         accum_ff, accum_in;
   logic                out_valid_ff, out_valid_in;
   logic                cancel_ff, cancel_in;
   logic                armed_ff, armed_in;

   logic               restart;
   logic               have_e;
   logic [62:0]        dt;
   logic signed [16:0] dh_raw;
   logic signed [16:0] dh;
   logic [16:0]        dh_abs;
   logic signed [17:0] acc_sum;
   logic               rearm;

   assign q_pop = q_valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      dir_in       = dir_ff;
      sess_in      = sess_ff;
      have_in      = have_ff;
      last_t_in    = last_t_ff;
      last_h_in    = last_h_ff;
      wait_in      = wait_ff;
      seen_in      = seen_ff;
      accum_in     = accum_ff;
      cancel_in    = cancel_ff;
      armed_in     = armed_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      restart = (q_item.direction != dir_ff) || (q_sid != sess_ff)
                || (have_ff && (q_item.sim_time_ns < last_t_ff));
      have_e  = have_ff && !restart;
      dt      = have_e ? q_item.sim_time_ns - last_t_ff : 63'd0;
      dh_raw  = $signed({1'b0, q_item.heading_cdeg}) - $signed({1'b0, last_h_ff});
      if (!have_e) begin
         dh = 17'sd0;
      end else if (dh_raw > 17'sd18000) begin
         dh = dh_raw - 17'sd36000;
      end else if (dh_raw < -17'sd18000) begin
         dh = dh_raw + 17'sd36000;
      end else begin
         dh = dh_raw;
      end
      dh_abs  = dh[16] ? 17'(-dh) : 17'(dh);
      rearm   = (dt > {31'd0, cfg.max_gap_ns}) || (dh_abs > {2'b00, cfg.max_jump_cdeg});
      // a restart starts the accumulation from zero
      acc_sum = $signed({2'b00, (have_e ? accum_ff : 16'd0)})
                + (q_item.left ? -18'(dh) : 18'(dh));

      if (q_pop) begin
         out_valid_in = 1'b1;
         cancel_in    = 1'b0;
         if (q_item.clear) begin
            dir_in    = DIR_OFF;
            sess_in   = '0;
            have_in   = 1'b0;
            last_t_in = '0;
            last_h_in = '0;
            wait_in   = 1'b0;
            seen_in   = 1'b0;
            accum_in  = '0;
            armed_in  = 1'b0;
         end else if (have_e && (q_item.sim_time_ns == last_t_ff)) begin
            // repeated timestamp: hold everything
            armed_in = wait_ff;
         end else begin
            dir_in    = q_item.direction;
            sess_in   = q_sid;
            have_in   = 1'b1;
            last_t_in = q_item.sim_time_ns;
            last_h_in = q_item.heading_cdeg;
            wait_in   = have_e && wait_ff;
            seen_in   = have_e && seen_ff;
            accum_in  = have_e ? accum_ff : 16'd0;
            if (rearm) begin
               wait_in  = 1'b0;
               seen_in  = 1'b0;
               accum_in = '0;
            end else if (q_item.speed_ok) begin
               if (!wait_in) begin
                  if (q_item.opposite_steer) begin
                     seen_in  = 1'b0;
                     accum_in = '0;
                  end else begin
                     seen_in = seen_in || q_item.turning_steer;
                     if (seen_in) begin
                        priority if (acc_sum < 18'sd0) begin
                           accum_in = '0;
                        end else if (acc_sum > 18'sd65535) begin
                           accum_in = 16'hFFFF;
                        end else begin
                           accum_in = acc_sum[15:0];
                        end
                        wait_in = (accum_in >= cfg.min_turn_cdeg);
                     end
                  end
               end
               if (!q_item.opposite_steer && wait_in && q_item.centred_steer) begin
                  cancel_in = 1'b1;
                  dir_in    = DIR_OFF;
                  sess_in   = '0;
                  have_in   = 1'b0;
                  last_t_in = '0;
                  last_h_in = '0;
                  wait_in   = 1'b0;
                  seen_in   = 1'b0;
                  accum_in  = '0;
               end
            end
            armed_in = wait_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= DIR_OFF;
         sess_ff      <= '0;
         have_ff      <= 1'b0;
         last_t_ff    <= '0;
         last_h_ff    <= '0;
         wait_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         accum_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         dir_ff       <= dir_in;
         sess_ff      <= sess_in;
         have_ff      <= have_in;
         last_t_ff    <= last_t_in;
         last_h_ff    <= last_h_in;
         wait_ff      <= wait_in;
         seen_ff      <= seen_in;
         accum_ff     <= accum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cancel_ff <= cancel_in;
      armed_ff  <= armed_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_cancel = cancel_ff;
   assign rsp_armed  = armed_ff;

endmodule

[rtl/turn_signal_auto_cancel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turn_signal_auto_cancel
// Decides per vehicle-state sample whether a turn indicator self-cancels.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one vehicle-state sample per transaction (tvalid/tready/tdata).
//   rsp_*  : one decision per sample, in order: cancel and armed flags.
//   csr_*  : write-only register port; write only while the block is idle.
// Flow: the sample is classified on entry and written into a two-entry queue;
//   the tracker pops one entry per cycle unless a held response stalls it,
//   updates its state and loads the response register, raising rsp_tvalid.
// Throughput: one sample per cycle while rsp_tready is high; the tracker update
//   (timestamp compare, heading delta and accumulate) is combinational.
// Stall: while rsp_tready is low the response register holds, the queue fills
//   and req_tready drops once both queue entries are taken.
// Reset: synchronous, active high; clears tracking state, empties the queue and
//   restores the register defaults. Samples are accepted once reset is low.
// ----------------------------------------------------------------------------
module turn_signal_auto_cancel
   import tsac_pkg::*;
#(
   parameter int SESSION_ID_BITS = SESSION_ID_BITS_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // direction[1:0], hazard, fresh, sample_valid, session_valid,
   // session_id[31:0], sim_time_ns[62:0], heading_cdeg[15:0],
   // steering_mrad[11:0], speed_mm_s[17:0], zero fill
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // cancel, armed, zero fill
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int SidBits = (SESSION_ID_BITS < SESSION_ID_PORT_BITS)
                            ? SESSION_ID_BITS : SESSION_ID_PORT_BITS;
   localparam int QBits   = $bits(item_type) + SidBits;

   cfg_type          cfg;
   item_type         front_item;
   logic [SidBits-1:0] front_sid;
   logic [QBits-1:0] q_out;
   queue_status_type q_status;
   logic             q_pop;
   logic             rsp_cancel;
   logic             rsp_armed;

   tsac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tsac_front #(.SID_BITS(SidBits)) u_front (
      .cfg           (cfg),
      .direction     (req_tdata[1:0]),
      .hazard        (req_tdata[2]),
      .fresh         (req_tdata[3]),
      .sample_valid  (req_tdata[4]),
      .session_valid (req_tdata[5]),
      .session_id    (req_tdata[37:6]),
      .sim_time_ns   (req_tdata[100:38]),
      .heading_cdeg  (req_tdata[116:101]),
      .steering_mrad (req_tdata[128:117]),
      .speed_mm_s    (req_tdata[146:129]),
      .item          (front_item),
      .sid           (front_sid)
   );

   tsac_queue #(.DATA_BITS(QBits)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data ({front_sid, front_item}),
      .pop       (q_pop),
      .pop_data  (q_out),
      .status    (q_status)
   );

   // refuse transactions while reset is held
   assign req_tready = !q_status.full && !reset;

   tsac_back #(.SID_BITS(SidBits)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (!q_status.empty),
      .q_item     (item_type'(q_out[$bits(item_type)-1:0])),
      .q_sid      (q_out[QBits-1:$bits(item_type)]),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_cancel (rsp_cancel),
      .rsp_armed  (rsp_armed)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS-2){1'b0}}, rsp_armed, rsp_cancel};

`ifndef NO_ASSERTIONS
   // a cancel always drops the armed latch in the same decision
   a_cancel_not_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("cancel reported while still armed");

   // no response appears without a queued sample behind it
   a_no_phantom_rsp: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && q_status.empty) |=> !rsp_tvalid)
      else $error("response without a queued sample");

   // reset leaves queue empty and no response pending
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && q_status.empty))
      else $error("state not cleared by reset");
`endif

endmodule
